>>> rtl/tcst_pkg.sv
// ----------------------------------------------------------------------------
// tcst_pkg
// Shared constants and types for the TCP connect statistics tracker.
// ----------------------------------------------------------------------------
package tcst_pkg;

  localparam int FLOW_ENTRIES   = 1024;
  localparam int SOCKET_ENTRIES = 1024;
  localparam int FLOW_IDX_W     = $clog2(FLOW_ENTRIES);
  localparam int SOCK_IDX_W     = $clog2(SOCKET_ENTRIES);
  localparam int CLR_ENTRIES    = (FLOW_ENTRIES > SOCKET_ENTRIES) ? FLOW_ENTRIES
                                                                  : SOCKET_ENTRIES;
  localparam int CLR_IDX_W      = $clog2(CLR_ENTRIES);

  localparam logic [3:0]  ST_ESTABLISHED = 4'd1;
  localparam logic [3:0]  ST_SYN_SENT    = 4'd2;
  localparam logic [3:0]  ST_SYN_RECV    = 4'd3;
  localparam logic [3:0]  ST_CLOSE       = 4'd7;
  localparam logic [3:0]  ST_LISTEN      = 4'd10;
  localparam logic [15:0] FAMILY_IPV4    = 16'd2;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;

  typedef enum logic [2:0] {
    STAT_FILTERED = 3'd0,
    STAT_NONE     = 3'd1,
    STAT_ATTEMPT  = 3'd2,
    STAT_SUCCESS  = 3'd3,
    STAT_FAILURE  = 3'd4
  } status_t;

  typedef struct packed {
    logic        present;
    logic [31:0] attempts;
    logic [31:0] failures;
    logic [31:0] lat_count;
    logic [63:0] lat_sum;
  } flow_entry_t;

  typedef struct packed {
    logic        started;
    logic [63:0] start_time;
  } sock_entry_t;

endpackage

>>> rtl/tcp_connect_stats_tracker.sv
// ----------------------------------------------------------------------------
// tcp_connect_stats_tracker
// Per-flow connect attempt, failure and latency counters, with per-socket
// start timestamps, held in two single-port synchronous tables.
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// in_      input      in_valid / in_ready    socket state-change event
// out_     output     out_valid / out_ready  flow counters after the event
//
// Each transaction runs as a registered table read on accept, then a
// read-modify-write in the update stage once the output register is free.
// After reset a clearing pass over all CLR_ENTRIES (1024) addresses zeroes
// every entry of both tables; in_ready stays low throughout.
// A result waits in the output register; the next event is taken meanwhile
// and holds in the update stage until the output register frees.
module tcp_connect_stats_tracker
  import tcst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_old_state,
  input  logic [3:0]  in_new_state,
  input  logic [15:0] in_addr_family,
  input  logic [7:0]  in_proto_number,
  input  logic        in_kernel_task,
  input  logic [9:0]  in_socket_slot,
  input  logic [9:0]  in_flow_slot,
  input  logic [63:0] in_now_ns,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_attempt_total,
  output logic [31:0] out_failure_total,
  output logic [31:0] out_latency_samples,
  output logic [63:0] out_latency_total,
  output logic [63:0] out_latency_now
);

  flow_entry_t flow_mem [FLOW_ENTRIES];
  sock_entry_t sock_mem [SOCKET_ENTRIES];

  flow_entry_t flow_q_r;
  sock_entry_t sock_q_r;

  logic                  clr_active_r;
  logic [CLR_IDX_W-1:0]  clr_idx_r;

  logic                  s1_valid_r;
  logic [3:0]            s1_old_r;
  logic [3:0]            s1_new_r;
  logic                  s1_pass_r;
  logic [SOCK_IDX_W-1:0] s1_ss_r;
  logic [FLOW_IDX_W-1:0] s1_fs_r;
  logic [63:0]           s1_now_r;

  logic        out_valid_r;
  status_t     out_status_r;
  logic [31:0] out_att_r;
  logic [31:0] out_fail_r;
  logic [31:0] out_cnt_r;
  logic [63:0] out_sum_r;
  logic [63:0] out_lat_r;

  logic        accept;
  logic        fire;
  logic        is_attempt;
  logic        from_syn;
  logic        is_success;
  logic        is_failure;
  logic        closing;
  logic        measured;
  logic [63:0] lat_now;
  status_t     status_nxt;
  flow_entry_t flow_nxt;
  sock_entry_t sock_nxt;

  assign in_ready = !clr_active_r && !s1_valid_r;
  assign accept   = in_valid && in_ready;
  assign fire     = s1_valid_r && (!out_valid_r || out_ready);

  always_comb begin
    is_attempt = (s1_old_r == ST_CLOSE  && s1_new_r == ST_SYN_SENT) ||
                 (s1_old_r == ST_LISTEN && s1_new_r == ST_SYN_RECV);
    from_syn   = (s1_old_r == ST_SYN_SENT) || (s1_old_r == ST_SYN_RECV);
    is_success = !is_attempt && from_syn && (s1_new_r == ST_ESTABLISHED);
    is_failure = !is_attempt && from_syn && (s1_new_r == ST_CLOSE);
    closing    = (s1_new_r == ST_CLOSE) && (s1_old_r != ST_CLOSE);
    measured   = is_success && sock_q_r.started;
    lat_now    = measured ? (s1_now_r - sock_q_r.start_time) : 64'd0;

    flow_nxt = flow_q_r;
    sock_nxt = sock_q_r;
    priority if (is_attempt) begin
      status_nxt          = STAT_ATTEMPT;
      sock_nxt.start_time = s1_now_r;
      sock_nxt.started    = 1'b1;
      if (!flow_q_r.present) begin
        flow_nxt = '0;
      end
      flow_nxt.present  = 1'b1;
      flow_nxt.attempts = flow_nxt.attempts + 32'd1;
    end else if (is_success) begin
      status_nxt = STAT_SUCCESS;
      if (measured) begin
        sock_nxt.started = 1'b0;
        if (flow_q_r.present) begin
          flow_nxt.lat_sum   = flow_q_r.lat_sum + lat_now;
          flow_nxt.lat_count = flow_q_r.lat_count + 32'd1;
        end
      end
    end else if (is_failure) begin
      status_nxt = STAT_FAILURE;
      if (flow_q_r.present) begin
        flow_nxt.failures = flow_q_r.failures + 32'd1;
      end
    end else begin
      status_nxt = STAT_NONE;
    end
    if (closing) begin
      sock_nxt.started = 1'b0;
    end
  end

  // tables: clearing pass, write-back, registered read
  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      flow_mem[clr_idx_r[FLOW_IDX_W-1:0]] <= '0;
    end else if (fire && s1_pass_r) begin
      flow_mem[s1_fs_r] <= flow_nxt;
    end
    if (accept) begin
      flow_q_r <= flow_mem[in_flow_slot[FLOW_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      sock_mem[clr_idx_r[SOCK_IDX_W-1:0]] <= '0;
    end else if (fire && s1_pass_r) begin
      sock_mem[s1_ss_r] <= sock_nxt;
    end
    if (accept) begin
      sock_q_r <= sock_mem[in_socket_slot[SOCK_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (clr_active_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == CLR_IDX_W'(CLR_ENTRIES - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_old_r  <= in_old_state;
      s1_new_r  <= in_new_state;
      s1_pass_r <= (in_addr_family == FAMILY_IPV4) && (in_proto_number == PROTO_TCP) &&
                   !in_kernel_task;
      s1_ss_r   <= in_socket_slot[SOCK_IDX_W-1:0];
      s1_fs_r   <= in_flow_slot[FLOW_IDX_W-1:0];
      s1_now_r  <= in_now_ns;
    end
    if (fire) begin
      if (!s1_pass_r) begin
        out_status_r <= STAT_FILTERED;
        out_att_r    <= '0;
        out_fail_r   <= '0;
        out_cnt_r    <= '0;
        out_sum_r    <= '0;
        out_lat_r    <= '0;
      end else begin
        out_status_r <= status_nxt;
        out_att_r    <= flow_nxt.present ? flow_nxt.attempts  : 32'd0;
        out_fail_r   <= flow_nxt.present ? flow_nxt.failures  : 32'd0;
        out_cnt_r    <= flow_nxt.present ? flow_nxt.lat_count : 32'd0;
        out_sum_r    <= flow_nxt.present ? flow_nxt.lat_sum   : 64'd0;
        out_lat_r    <= lat_now;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_attempt_total   = out_att_r;
  assign out_failure_total   = out_fail_r;
  assign out_latency_samples = out_cnt_r;
  assign out_latency_total   = out_sum_r;
  assign out_latency_now     = out_lat_r;

endmodule

>>> rtl/tcst_checker.sv
// ----------------------------------------------------------------------------
// tcst_checker
// Port-level checks for the TCP connect statistics tracker.
// ----------------------------------------------------------------------------
module tcst_checker
  import tcst_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [31:0] out_attempt_total,
  input logic [31:0] out_failure_total,
  input logic [31:0] out_latency_samples,
  input logic [63:0] out_latency_total,
  input logic [63:0] out_latency_now
);

  // clearing pass: no transaction straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("transaction possible straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_latency_total) && $stable(out_latency_now))
    else $error("stalled result changed");

  a_filtered_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_FILTERED |->
      out_attempt_total == 32'd0 && out_failure_total == 32'd0 &&
      out_latency_samples == 32'd0 && out_latency_total == 64'd0 &&
      out_latency_now == 64'd0)
    else $error("filtered transaction with non-zero fields");

  a_latency_only_success: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_SUCCESS |-> out_latency_now == 64'd0)
    else $error("latency reported outside a success");

endmodule

bind tcp_connect_stats_tracker tcst_checker u_tcst_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_status          (out_status),
  .out_attempt_total   (out_attempt_total),
  .out_failure_total   (out_failure_total),
  .out_latency_samples (out_latency_samples),
  .out_latency_total   (out_latency_total),
  .out_latency_now     (out_latency_now)
);
